// ===== sv/ddts_pkg.sv =====
// ddts_pkg: types, constants and the arctangent table of the turn steering block
// no dependencies; the CORDIC, square root, divider, sequencer and top files import it
`timescale 1ns / 1ps
`default_nettype none

package ddts_pkg;

  // fixed-point angle constants (radians times 4096 and times 2^24)
  localparam logic [12:0] HALF_PI_Q12 = 13'd6434;
  localparam logic [13:0] PI_Q12      = 14'd12868;
  localparam logic [24:0] HALF_PI_Q24 = 25'd26353589;
  localparam logic [11:0] ROUND_Q12   = 12'd2048;
  localparam int          ATAN_LEN    = 24;

  // iteration counts of the square root and divider units
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 14;

  // register reset values
  localparam logic [13:0] HARD_RST = 14'd6434;
  localparam logic [13:0] SOFT_RST = 14'd5004;
  localparam logic [13:0] NONE_RST = 14'd715;
  localparam logic [13:0] MAX_RST  = 14'd2560;

  typedef enum logic [1:0] {
    REG_HARD_TURN = 2'd0,
    REG_SOFT_TURN = 2'd1,
    REG_NO_TURN   = 2'd2,
    REG_MAX_SPEED = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2
  } turn_mode_t;

  typedef enum logic [1:0] {
    MUL_AX,
    MUL_AY,
    MUL_SOFT
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ITER,
    S_MODE,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } seq_state_t;

  // sequencer to datapath
  typedef struct packed {
    logic     in_ready;
    logic     cordic_start;
    logic     sqrt_start;
    logic     sq_ld;
    mul_sel_t mul_sel;
    logic     mode_upd;
    logic     prod_ld;
    logic     div_start;
    logic     out_ld;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic cordic_busy;
    logic sqrt_busy;
    logic div_busy;
    logic div_need;
    logic out_free;
  } sts_t;

  // atan(2^-i) in radians times 2^24
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ddts_if.sv =====
// ddts_if: handshake channels of the turn steering block (heading in, speeds out, config)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ddts_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  modport source (output valid, heading_x, heading_y, input ready);
  modport sink   (input valid, heading_x, heading_y, output ready);
endinterface

interface ddts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic        [1:0]  turn_mode;
  modport source (output valid, left_speed, right_speed, turn_mode, input ready);
  modport sink   (input valid, left_speed, right_speed, turn_mode, output ready);
endinterface

interface ddts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ddts_cordic.sv =====
// ddts_cordic: iterative vectoring CORDIC, first-quadrant angle of (ax, ay)
// depends on ddts_pkg (arctangent table, angle constants)
`timescale 1ns / 1ps
`default_nettype none

module ddts_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] ax,
  input  wire logic [15:0] ay,
  output logic             busy,
  output logic [12:0]      angle
);
  import ddts_pkg::*;

  localparam int CW = $clog2(CORDIC_STAGES);

  logic               iter_r, iter_nxt;
  logic               fin_r, fin_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [26:0] cx_r, cx_nxt;
  logic signed [26:0] cy_r, cy_nxt;
  logic signed [27:0] z_r, z_nxt;
  logic               zero_x_r, zero_x_nxt;
  logic               zero_y_r, zero_y_nxt;
  logic [12:0]        angle_r, angle_nxt;

  logic signed [26:0] dx, dy;
  logic signed [27:0] step_z;
  logic [24:0]        zc;
  logic [25:0]        zsum;
  logic [12:0]        a_rnd;

  // one micro-rotation per cycle through shifters and adders reused by every step
  assign dx     = cy_r >>> cnt_r;
  assign dy     = cx_r >>> cnt_r;
  assign step_z = $signed({4'b0000, atan_q24(5'(cnt_r))});

  // clamp the accumulated angle and round it to nearest, in radians times 4096
  always_comb begin
    if (z_r[27]) begin
      zc = '0;
    end else if (z_r > $signed({3'b000, HALF_PI_Q24})) begin
      zc = HALF_PI_Q24;
    end else begin
      zc = z_r[24:0];
    end
    zsum  = {1'b0, zc} + {14'd0, ROUND_Q12};
    a_rnd = (zsum[24:12] > HALF_PI_Q12) ? HALF_PI_Q12 : zsum[24:12];
  end

  // iteration control and datapath
  always_comb begin
    iter_nxt   = iter_r;
    fin_nxt    = fin_r;
    cnt_nxt    = cnt_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    z_nxt      = z_r;
    zero_x_nxt = zero_x_r;
    zero_y_nxt = zero_y_r;
    angle_nxt  = angle_r;
    if (start) begin
      iter_nxt   = 1'b1;
      fin_nxt    = 1'b0;
      cnt_nxt    = '0;
      cx_nxt     = $signed({3'b000, ax, 8'h00});
      cy_nxt     = $signed({3'b000, ay, 8'h00});
      z_nxt      = '0;
      zero_x_nxt = (ax == 16'd0);
      zero_y_nxt = (ay == 16'd0);
    end else if (iter_r) begin
      if (!cy_r[26]) begin
        cx_nxt = cx_r + dx;
        cy_nxt = cy_r - dy;
        z_nxt  = z_r + step_z;
      end else begin
        cx_nxt = cx_r - dx;
        cy_nxt = cy_r + dy;
        z_nxt  = z_r - step_z;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(CORDIC_STAGES - 1)) begin
        iter_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      fin_nxt = 1'b0;
      // vectors on an axis override the rotation result
      if (zero_y_r) begin
        angle_nxt = '0;
      end else if (zero_x_r) begin
        angle_nxt = HALF_PI_Q12;
      end else begin
        angle_nxt = a_rnd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      iter_r <= iter_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    z_r      <= z_nxt;
    zero_x_r <= zero_x_nxt;
    zero_y_r <= zero_y_nxt;
    angle_r  <= angle_nxt;
  end

  assign busy  = iter_r | fin_r;
  assign angle = angle_r;

endmodule

`default_nettype wire

// ===== sv/ddts_isqrt.sv =====
// ddts_isqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on ddts_pkg (step count)
`timescale 1ns / 1ps
`default_nettype none

module ddts_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] v,
  output logic             busy,
  output logic [15:0]      root
);
  import ddts_pkg::*;

  localparam int CW = $clog2(SQRT_STEPS);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   v_r, v_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [15:0]   root_r, root_nxt;

  logic [18:0]   rem_sh;
  logic [18:0]   trial;
  logic [18:0]   diff;

  // bring down the next radicand pair and try the next root bit
  assign rem_sh = {rem_r, v_r[31:30]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = v;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      v_nxt   = {v_r[29:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_nxt  = diff[16:0];
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[16:0];
        root_nxt = {root_r[14:0], 1'b0};
      end
      if (cnt_r == CW'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== sv/ddts_div.sv =====
// ddts_div: restoring divider, one quotient bit per cycle, quotient below 2^14
// depends on ddts_pkg (step count)
`timescale 1ns / 1ps
`default_nettype none

module ddts_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [29:0] num,
  input  wire logic [14:0] den,
  output logic             busy,
  output logic [13:0]      quo
);
  import ddts_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [14:0]          rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] low_r, low_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [14:0]          den_r, den_nxt;

  logic [15:0]          sh;
  logic [15:0]          diff;

  // shift in the next dividend bit and subtract if it fits
  assign sh   = {rem_r, low_r[DIV_STEPS-1]};
  assign diff = sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // the upper dividend part is already below the divisor
      rem_nxt  = num[28:14];
      low_nxt  = num[13:0];
      q_nxt    = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      low_nxt = {low_r[DIV_STEPS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = diff[14:0];
        q_nxt   = {q_r[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt = sh[14:0];
        q_nxt   = {q_r[DIV_STEPS-2:0], 1'b0};
      end
      if (cnt_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

// ===== sv/ddts_seq.sv =====
// ddts_seq: sequencer that steps one heading word through the shared units
// depends on ddts_pkg (state enum, control and status structs)
`timescale 1ns / 1ps
`default_nettype none

module ddts_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ddts_pkg::sts_t sts,
  output ddts_pkg::ctl_t     ctl
);
  import ddts_pkg::*;

  seq_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (sts.in_valid) state_nxt = S_SQX;
      S_SQX:    state_nxt = S_SQY;
      S_SQY:    state_nxt = S_ITER;
      S_ITER:   if (!sts.cordic_busy && !sts.sqrt_busy) state_nxt = S_MODE;
      S_MODE:   state_nxt = S_MUL;
      S_MUL:    state_nxt = sts.div_need ? S_DIV_GO : S_OUT;
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV:    if (!sts.div_busy) state_nxt = S_OUT;
      S_OUT:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    ctl.mul_sel = MUL_AX;
    case (state_r)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      S_SQX: begin
        ctl.cordic_start = 1'b1;
        ctl.sq_ld        = 1'b1;
        ctl.mul_sel      = MUL_AX;
      end
      S_SQY: begin
        ctl.sqrt_start = 1'b1;
        ctl.mul_sel    = MUL_AY;
      end
      S_MODE: begin
        ctl.mode_upd = 1'b1;
      end
      S_MUL: begin
        ctl.mul_sel = MUL_SOFT;
        ctl.prod_ld = 1'b1;
      end
      S_DIV_GO: begin
        ctl.div_start = 1'b1;
      end
      S_OUT: begin
        ctl.out_ld = sts.out_free;
      end
      default: begin
        ctl.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/differential_drive_turn_steering.sv =====
// Differential-drive turn steering with hysteresis. Each heading word (x, y) gets its
// angle from an iterative vectoring CORDIC and its length from a digit-by-digit square
// root; the length clamped to the top speed setting is the base speed, and a three-state
// turn mode (none, soft, hard) picks the wheel speeds, swapped by the sign of the angle.
// One word is in flight at a time. Its run is set by the 16-step square root, or by the
// CORDIC when CORDIC_STAGES is above 16, and a soft turn also runs the 14-step divider.
// A finished result sits in an output register, so the next word is taken while it waits.
// Config writes are always accepted and meant for idle.
//
// top level; depends on ddts_pkg, ddts_if, ddts_cordic, ddts_isqrt, ddts_div, ddts_seq
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_turn_steering #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ddts_in_if.sink   in_chan,
  ddts_out_if.source out_chan,
  ddts_cfg_if.sink  cfg_chan
);
  import ddts_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // configuration registers
  logic [13:0] hard_r, soft_r, none_r, max_r;

  // item registers
  logic signed [15:0] x_r, y_r;
  logic [31:0]        sq_r;
  logic [13:0]        base_r;
  logic [13:0]        mag_r;
  logic               positive_r;
  logic               div_need_r;
  logic [27:0]        prod_r;
  turn_mode_t         mode_r, mode_nxt;

  // output register
  logic               out_valid_r;
  logic signed [15:0] left_r, right_r;
  logic [1:0]         tmode_r;

  logic [16:0] nx, ny;
  logic [15:0] ax, ay;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [31:0] sqrt_v;
  logic [29:0] div_num;
  logic [14:0] div_den;
  logic        cordic_busy, sqrt_busy, div_busy;
  logic [12:0] angle;
  logic [15:0] root;
  logic [13:0] quo;
  logic [13:0] mag;
  logic [13:0] base;
  logic        positive;
  logic        div_need;
  logic [13:0] f1;
  logic signed [15:0] s1, s2;

  // config write port
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r <= HARD_RST;
      soft_r <= SOFT_RST;
      none_r <= NONE_RST;
      max_r  <= MAX_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_HARD_TURN: hard_r <= cfg_chan.data;
        REG_SOFT_TURN: soft_r <= cfg_chan.data;
        REG_NO_TURN:   none_r <= cfg_chan.data;
        REG_MAX_SPEED: max_r  <= cfg_chan.data;
        default:       max_r  <= max_r;
      endcase
    end
  end

  // sequencer
  assign sts.in_valid    = in_chan.valid;
  assign sts.cordic_busy = cordic_busy;
  assign sts.sqrt_busy   = sqrt_busy;
  assign sts.div_busy    = div_busy;
  assign sts.div_need    = div_need_r;
  assign sts.out_free    = !out_valid_r || out_chan.ready;

  ddts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  assign in_chan.ready = ctl.in_ready;

  // input word capture
  always_ff @(posedge clk) begin
    if (ctl.in_ready && in_chan.valid) begin
      x_r <= in_chan.heading_x;
      y_r <= in_chan.heading_y;
    end
  end

  // component magnitudes
  assign nx = -{x_r[15], x_r};
  assign ny = -{y_r[15], y_r};
  assign ax = x_r[15] ? nx[15:0] : x_r;
  assign ay = y_r[15] ? ny[15:0] : y_r;

  // shared multiplier: x squared, y squared, then the soft-turn product
  always_comb begin
    case (ctl.mul_sel)
      MUL_AX: begin
        mul_a = ax;
        mul_b = ax;
      end
      MUL_AY: begin
        mul_a = ay;
        mul_b = ay;
      end
      MUL_SOFT: begin
        mul_a = {2'b00, base_r};
        mul_b = {2'b00, hard_r - mag_r};
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign sqrt_v = sq_r + mul_p;

  always_ff @(posedge clk) begin
    if (ctl.sq_ld) begin
      sq_r <= mul_p;
    end
    if (ctl.prod_ld) begin
      prod_r <= mul_p[27:0];
    end
  end

  ddts_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.cordic_start),
    .ax    (ax),
    .ay    (ay),
    .busy  (cordic_busy),
    .angle (angle)
  );

  ddts_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.sqrt_start),
    .v     (sqrt_v),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // rounded quotient: (2 * prod + h) / (2 * h)
  assign div_num = {1'b0, prod_r, 1'b0} + {16'd0, hard_r};
  assign div_den = {hard_r, 1'b0};

  ddts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // angle magnitude, direction and base speed
  assign mag      = x_r[15] ? (PI_Q12 - {1'b0, angle}) : {1'b0, angle};
  assign positive = (!y_r[15] && (y_r != 16'sd0)) || ((y_r == 16'sd0) && x_r[15]);
  assign base     = ({2'b00, max_r} < root) ? max_r : root[13:0];

  // mode update, checked in the order hard, soft, none
  always_comb begin
    mode_nxt = mode_r;
    if (mode_nxt == MODE_HARD && mag <= soft_r) begin
      mode_nxt = MODE_SOFT;
    end
    if (mode_nxt == MODE_SOFT) begin
      if (mag > hard_r) begin
        mode_nxt = MODE_HARD;
      end else if (mag <= none_r) begin
        mode_nxt = MODE_NONE;
      end
    end
    if (mode_nxt == MODE_NONE) begin
      if (mag > hard_r) begin
        mode_nxt = MODE_HARD;
      end else if (mag > none_r) begin
        mode_nxt = MODE_SOFT;
      end
    end
  end

  assign div_need = (mode_nxt == MODE_SOFT) && (hard_r != 14'd0) && (mag <= hard_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else if (ctl.mode_upd) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mode_upd) begin
      base_r     <= base;
      mag_r      <= mag;
      positive_r <= positive;
      div_need_r <= div_need;
    end
  end

  // wheel speeds for the current mode
  assign f1 = div_need_r ? quo : 14'd0;

  always_comb begin
    case (mode_r)
      MODE_SOFT: begin
        s1 = $signed({2'b00, f1});
        s2 = $signed({1'b0, base_r, 1'b0}) - $signed({2'b00, f1});
      end
      MODE_HARD: begin
        s1 = -$signed({2'b00, max_r});
        s2 = $signed({2'b00, max_r});
      end
      default: begin
        s1 = $signed({2'b00, base_r});
        s2 = $signed({2'b00, base_r});
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      left_r  <= positive_r ? s1 : s2;
      right_r <= positive_r ? s2 : s1;
      tmode_r <= mode_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.left_speed  = left_r;
  assign out_chan.right_speed = right_r;
  assign out_chan.turn_mode   = tmode_r;

  // a new word only enters with every unit at rest
  a_ready_units_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.in_ready |-> !(cordic_busy || sqrt_busy || div_busy))
    else $error("word accepted while a unit is busy");

  // the rounded soft factor never exceeds the base speed
  a_quo_le_base : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(div_busy) |-> quo <= base_r)
    else $error("soft speed above base speed");

  // the base speed is clamped to the maximum speed
  a_base_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mode_upd |=> base_r <= max_r)
    else $error("base speed above max speed");

  // a result is loaded only into a free output register
  a_out_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld && out_valid_r |-> out_chan.ready)
    else $error("result overwrites a waiting word");

endmodule

`default_nettype wire

// ===== sim/differential_drive_turn_steering_tb.sv =====
// differential_drive_turn_steering_tb: self-checking bench for the turn steering block
// drives heading words, rewrites the thresholds between phases and checks every speed word
// depends on ddts_pkg, ddts_if and differential_drive_turn_steering
`timescale 1ns / 1ps

module differential_drive_turn_steering_tb;
  import ddts_pkg::*;

  localparam int STAGES       = 16;
  localparam int PHASE_WORDS  = 130;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    turn_mode_t         mode;
  } wheel_cmd_t;

  typedef enum {IDLE_OFF, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_plan_t;

  // golden steering model plus the queue of speed words still owed by the block
  class steering_board;
    longint     hard_thr, soft_thr, no_turn_thr, top_speed;
    turn_mode_t mode_now;
    wheel_cmd_t wheels_due[$];
    int         errors;

    function new();
      hard_thr    = HARD_RST;
      soft_thr    = SOFT_RST;
      no_turn_thr = NONE_RST;
      top_speed   = MAX_RST;
      mode_now    = MODE_NONE;
      errors      = 0;
    endfunction

    function void note_reg(cfg_reg_t idx, logic [13:0] val);
      case (idx)
        REG_HARD_TURN: hard_thr    = val;
        REG_SOFT_TURN: soft_thr    = val;
        REG_NO_TURN:   no_turn_thr = val;
        REG_MAX_SPEED: top_speed   = val;
        default: ;
      endcase
    endfunction

    // atan(2^-i) in radians times 2^24
    function longint atan_rad(int i);
      case (i)
        0: return 13176795;  1: return 7778716;  2: return 4110060;  3: return 2086331;
        4: return 1047214;   5: return 524117;   6: return 262123;   7: return 131069;
        8: return 65536;     9: return 32768;    10: return 16384;   11: return 8192;
        12: return 4096;     13: return 2048;    14: return 1024;    15: return 512;
        16: return 256;      17: return 128;     18: return 64;      19: return 32;
        20: return 16;       21: return 8;       22: return 4;       23: return 2;
        default: return 0;
      endcase
    endfunction

    function longint root_floor(longint v);
      longint s;
      s = longint'($sqrt(real'(v)));
      while (s * s > v) s--;
      while ((s + 1) * (s + 1) <= v) s++;
      return s;
    endfunction

    // first-quadrant vectoring rotation, result in radians times 4096
    function longint quadrant_angle(longint ax, longint ay);
      longint cx, cy, z, dx, dy, a;
      if (ay == 0) return 0;
      if (ax == 0) return longint'(HALF_PI_Q12);
      cx = ax * 256;
      cy = ay * 256;
      z  = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z  += atan_rad(i);
        end else begin
          cx -= dx;
          cy += dy;
          z  -= atan_rad(i);
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(HALF_PI_Q24)) z = longint'(HALF_PI_Q24);
      a = (z + 2048) >> 12;
      return (a > longint'(HALF_PI_Q12)) ? longint'(HALF_PI_Q12) : a;
    endfunction

    function wheel_cmd_t predict_wheels(logic signed [15:0] hx, logic signed [15:0] hy);
      longint     x, y, ax, ay, len, base, mag, f1, s1, s2;
      logic       positive;
      wheel_cmd_t cmd;
      x    = hx;
      y    = hy;
      ax   = (x < 0) ? -x : x;
      ay   = (y < 0) ? -y : y;
      len  = root_floor(ax * ax + ay * ay);
      base = (len < top_speed) ? len : top_speed;
      mag  = quadrant_angle(ax, ay);
      if (x < 0) mag = longint'(PI_Q12) - mag;
      positive = (y > 0) || (y == 0 && x < 0);

      // hysteresis, checked hard then soft then none
      if (mode_now == MODE_HARD && mag <= soft_thr) mode_now = MODE_SOFT;
      if (mode_now == MODE_SOFT) begin
        if (mag > hard_thr) mode_now = MODE_HARD;
        else if (mag <= no_turn_thr) mode_now = MODE_NONE;
      end
      if (mode_now == MODE_NONE) begin
        if (mag > hard_thr) mode_now = MODE_HARD;
        else if (mag > no_turn_thr) mode_now = MODE_SOFT;
      end

      // wheel pair before the sign swap
      case (mode_now)
        MODE_SOFT: begin
          f1 = 0;
          if (hard_thr != 0 && mag <= hard_thr)
            f1 = (base * (hard_thr - mag) * 2 + hard_thr) / (2 * hard_thr);
          s1 = f1;
          s2 = 2 * base - f1;
        end
        MODE_HARD: begin
          s1 = -top_speed;
          s2 = top_speed;
        end
        default: begin
          s1 = base;
          s2 = base;
        end
      endcase
      cmd.left  = positive ? s1[15:0] : s2[15:0];
      cmd.right = positive ? s2[15:0] : s1[15:0];
      cmd.mode  = mode_now;
      return cmd;
    endfunction

    function void note_heading(logic signed [15:0] hx, logic signed [15:0] hy);
      wheels_due = {wheels_due, predict_wheels(hx, hy)};
    endfunction

    function void check_speeds(logic [15:0] l, logic [15:0] r, logic [1:0] m);
      wheel_cmd_t want;
      if (wheels_due.size() == 0) begin
        $error("speed word with no heading pending: left %0d right %0d mode %0d",
               $signed(l), $signed(r), m);
        errors++;
        return;
      end
      want = wheels_due.pop_front();
      if (l !== want.left) begin
        $error("left_speed: expected %0d, actual %0d", want.left, $signed(l));
        errors++;
      end
      if (r !== want.right) begin
        $error("right_speed: expected %0d, actual %0d", want.right, $signed(r));
        errors++;
      end
      if (m !== want.mode) begin
        $error("turn_mode: expected %0d, actual %0d", want.mode, m);
        errors++;
      end
    endfunction

    function int pending();
      return wheels_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  steering_board board;

  ddts_in_if  in_chan ();
  ddts_out_if out_chan ();
  ddts_cfg_if cfg_chan ();

  differential_drive_turn_steering #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_speeds(out_chan.left_speed, out_chan.right_speed, out_chan.turn_mode);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idle(input idle_plan_t plan);
    send_idle_pct  = (plan == IDLE_SEND) ? 77 : (plan == IDLE_BOTH) ? 35 : 0;
    recv_stall_pct = (plan == IDLE_RECV) ? 77 : (plan == IDLE_BOTH) ? 35 : 0;
  endtask

  // valid stays high after acceptance until the next word or a gap replaces it
  task automatic push_heading(input logic signed [15:0] hx, input logic signed [15:0] hy);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.heading_x <= hx;
    in_chan.heading_y <= hy;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_heading(hx, hy);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [13:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    board.note_reg(idx, val);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // drop valid and wait for every owed speed word, then a short quiet gap
  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // vector at a chosen angle, mostly near one of the thresholds
  task automatic polar_heading(output logic signed [15:0] hx, output logic signed [15:0] hy);
    int  target, rad, pick;
    real th;
    pick = $urandom_range(0, 3);
    case (pick)
      0: target = int'(board.hard_thr);
      1: target = int'(board.soft_thr);
      2: target = int'(board.no_turn_thr);
      default: target = $urandom_range(0, 12868);
    endcase
    if (pick != 3) target = target + $urandom_range(0, 80) - 40;
    if (target < 0) target = 0;
    if (target > 12868) target = 12868;
    case ($urandom_range(0, 2))
      0: rad = $urandom_range(0, 64);
      1: rad = $urandom_range(0, 2 * int'(board.top_speed) + 2);
      default: rad = $urandom_range(0, 32767);
    endcase
    th = real'(target) / 4096.0;
    if ($urandom_range(0, 1)) th = -th;
    hx = clip16(int'(real'(rad) * $cos(th)));
    hy = clip16(int'(real'(rad) * $sin(th)));
  endtask

  task automatic random_heading(output logic signed [15:0] hx, output logic signed [15:0] hy);
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      hx = 16'($urandom);
      hy = 16'($urandom);
    end else if (k < 85) begin
      polar_heading(hx, hy);
    end else if (k < 93) begin
      hx = $urandom_range(0, 1) ? 16'($urandom) : clip16($urandom_range(0, 16) - 8);
      hy = 16'sd0;
      if ($urandom_range(0, 1)) begin
        hy = hx;
        hx = 16'sd0;
      end
    end else begin
      hx = clip16($urandom_range(0, 16) - 8);
      hy = clip16($urandom_range(0, 16) - 8);
    end
  endtask

  task automatic run_phase(input logic [13:0] hard, input logic [13:0] soft_lim,
                           input logic [13:0] no_turn, input logic [13:0] top,
                           input idle_plan_t plan);
    logic signed [15:0] hx, hy;
    write_reg(REG_HARD_TURN, hard);
    write_reg(REG_SOFT_TURN, soft_lim);
    write_reg(REG_NO_TURN, no_turn);
    write_reg(REG_MAX_SPEED, top);
    set_idle(plan);
    repeat (PHASE_WORDS) begin
      random_heading(hx, hy);
      push_heading(hx, hy);
    end
    settle();
  endtask

  initial begin
    logic [13:0] h, s, n;
    board             = new();
    quiet_cycles      = 0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.heading_x = '0;
    in_chan.heading_y = '0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = REG_HARD_TURN;
    cfg_chan.data     = '0;
    out_chan.ready    = 1'b0;
    set_idle(IDLE_OFF);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed words under reset thresholds: corners, axes, zero, mode walk
    push_heading(16'sd32767, 16'sd32767);
    push_heading(-16'sd32768, -16'sd32768);
    push_heading(16'sd0, 16'sd0);          // zero vector drops hard straight to none
    push_heading(-16'sd32768, 16'sd0);     // negative x axis counts as positive angle
    push_heading(16'sd32767, 16'sd0);
    push_heading(16'sd0, 16'sd32767);
    push_heading(16'sd0, -16'sd32768);
    push_heading(-16'sd1, 16'sd0);
    push_heading(16'sd1, 16'sd0);
    push_heading(16'sd0, 16'sd1);
    push_heading(16'sd0, -16'sd1);
    push_heading(-16'sd32768, 16'sd1);
    push_heading(-16'sd32768, -16'sd1);
    push_heading(16'sd1000, 16'sd0);
    push_heading(16'sd1000, 16'sd1000);
    push_heading(16'sd0, 16'sd1000);       // exactly at the hard threshold stays soft
    push_heading(-16'sd1000, 16'sd1000);
    push_heading(16'sd1000, -16'sd1000);
    push_heading(16'sd1000, 16'sd100);
    push_heading(-16'sd1000, -16'sd1000);
    push_heading(16'sd1000, 16'sd10);      // hard to soft to none in one word
    push_heading(16'sd100, 16'sd40);
    push_heading(-16'sd5, 16'sd3);
    push_heading(16'sd2560, 16'sd0);
    push_heading(16'sd2561, 16'sd1);
    settle();

    // random phases over several threshold sets and idling plans
    run_phase(14'd6434, 14'd5004, 14'd715, 14'd2560, IDLE_OFF);
    run_phase(14'd0, 14'd0, 14'd0, 14'd0, IDLE_SEND);
    run_phase(14'd16383, 14'd16383, 14'd16383, 14'd16383, IDLE_RECV);
    run_phase(14'd12868, 14'd12868, 14'd0, 14'd16383, IDLE_BOTH);
    run_phase(14'd2000, 14'd6000, 14'd3000, 14'd300, IDLE_OFF);
    h = 14'($urandom_range(1, 12868));
    s = 14'($urandom_range(0, h));
    n = 14'($urandom_range(0, s));
    run_phase(h, s, n, 14'($urandom_range(0, 16383)), IDLE_SEND);
    run_phase(14'd1, 14'd0, 14'd0, 14'd1, IDLE_RECV);
    h = 14'($urandom_range(1, 12868));
    s = 14'($urandom_range(0, h));
    n = 14'($urandom_range(0, s));
    run_phase(h, s, n, 14'($urandom_range(0, 4000)), IDLE_BOTH);

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ddts_pkg.sv
sv/ddts_if.sv
sv/ddts_cordic.sv
sv/ddts_isqrt.sv
sv/ddts_div.sv
sv/ddts_seq.sv
sv/differential_drive_turn_steering.sv
sim/differential_drive_turn_steering_tb.sv
